// ===== rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  // fixed field widths
  localparam int ACT_W  = 4;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;

  // default list depth
  localparam int CAPACITY_DEF = 16;

  // action codes, 10 to 15 are unused and do nothing
  typedef enum logic [ACT_W-1:0] {
    ACT_READ_AT    = 4'd0,
    ACT_INSERT_AT  = 4'd1,
    ACT_DELETE_AT  = 4'd2,
    ACT_PUSH_FRONT = 4'd3,
    ACT_POP_FRONT  = 4'd4,
    ACT_PUSH_BACK  = 4'd5,
    ACT_POP_BACK   = 4'd6,
    ACT_PEEK_FRONT = 4'd7,
    ACT_PEEK_BACK  = 4'd8,
    ACT_CLEAR      = 4'd9
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // one request beat
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  // status and data part of one result beat
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value_out;
  } rsp_head_t;

endpackage

// ===== rtl/ile_req_if.sv =====
// ----------------------------------------------------------------------------
// ile_req_if
// Request channel: valid/ready handshake with action, position and value.
// ----------------------------------------------------------------------------
interface ile_req_if;
  logic                             valid;
  logic                             ready;
  logic [ile_pkg::ACT_W-1:0]        action;
  logic [ile_pkg::POS_W-1:0]        position;
  logic signed [ile_pkg::DATA_W-1:0] value_in;

  modport source (output valid, action, position, value_in, input ready);
  modport sink   (input valid, action, position, value_in, output ready);
endinterface

// ===== rtl/ile_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ile_rsp_if
// Result channel: valid/ready handshake with status, value, count and empty.
// ----------------------------------------------------------------------------
interface ile_rsp_if #(
  parameter int CNT_W = 5
);
  logic                              valid;
  logic                              ready;
  ile_pkg::status_t                  status;
  logic signed [ile_pkg::DATA_W-1:0] value_out;
  logic [CNT_W-1:0]                  item_count;
  logic                              is_empty;

  modport source (output valid, status, value_out, item_count, is_empty, input ready);
  modport sink   (input valid, status, value_out, item_count, is_empty, output ready);
endinterface

// ===== rtl/indexed_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Bounded ordered list of signed 32-bit items with indexed insert/delete.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat: action, position and value_in.
//   out_ch returns exactly one result per request, in order: status,
//   value_out (zero unless the status is ok), item_count and is_empty.
//   A request beat is registered, executed against the list once the
//   result register has room (every entry has its own shift mux, so insert
//   and delete finish in the cycle they execute) and its result is
//   registered for out_ch. Throughput is one request per cycle while
//   out_ch does not stall.
//   Reset empties the list; entry contents are not cleared and only
//   entries below the count are ever read.
//   When out_ch stalls, the held result waits in the output register and
//   the next request waits in the input register; in_ch.ready drops only
//   when both are full.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ile_req_if.sink    in_ch,
  ile_rsp_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  ile_pkg::req_t      in_req;
  ile_pkg::req_t      req;
  logic               req_valid;
  logic               step;
  logic               out_free;
  ile_pkg::rsp_head_t head_nxt;
  ile_pkg::rsp_head_t head_q;
  logic [CNT_W-1:0]   count_nxt;
  logic               empty_nxt;

  // request beat packing
  assign in_req.action   = in_ch.action;
  assign in_req.position = in_ch.position;
  assign in_req.value_in = in_ch.value_in;

  // execute when a request is held and the result register has room
  assign step = req_valid && out_free;

  ile_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (in_req),
    .step      (step),
    .req_valid (req_valid),
    .req       (req)
  );

  ile_list_core #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req       (req),
    .rsp_head  (head_nxt),
    .count_nxt (count_nxt),
    .empty_nxt (empty_nxt)
  );

  ile_out_stage #(
    .CNT_W (CNT_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .free      (out_free),
    .head_in   (head_nxt),
    .count_in  (count_nxt),
    .empty_in  (empty_nxt),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head_out  (head_q),
    .count_out (out_ch.item_count),
    .empty_out (out_ch.is_empty)
  );

  // result beat unpacking
  assign out_ch.status    = head_q.status;
  assign out_ch.value_out = head_q.value_out;

endmodule

// ===== rtl/ile_in_stage.sv =====
// ----------------------------------------------------------------------------
// ile_in_stage
// Input register: captures one request beat and holds it until the list
// core executes it.
// ----------------------------------------------------------------------------
module ile_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ile_pkg::req_t in_req,
  input  logic          step,
  output logic          req_valid,
  output ile_pkg::req_t req
);

  logic          valid_r;
  ile_pkg::req_t req_r;

  // free when empty or when the held beat executes this cycle
  assign in_ready  = !valid_r || step;
  assign req_valid = valid_r;
  assign req       = req_r;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

endmodule

// ===== rtl/ile_list_core.sv =====
// ----------------------------------------------------------------------------
// ile_list_core
// List storage and count with one shift mux per entry; decodes a request,
// checks it, and updates the list in the cycle it executes.
// ----------------------------------------------------------------------------
module ile_list_core #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ile_pkg::req_t        req,
  output ile_pkg::rsp_head_t   rsp_head,
  output logic [CNT_W-1:0]     count_nxt,
  output logic                 empty_nxt
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;

  logic signed [ile_pkg::DATA_W-1:0] entries_r [CAPACITY];
  logic signed [ile_pkg::DATA_W-1:0] ent_nxt   [CAPACITY];
  logic [CNT_W-1:0]                  count_r;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] last_idx;
  logic [CMP_W-1:0] tgt;
  logic             do_put;
  logic             do_get;
  logic             do_rem;
  logic             do_clr;
  ile_pkg::status_t status;
  logic             put_ok;
  logic             get_ok;
  logic             rem_ok;

  assign cnt_ext  = CMP_W'(count_r);
  assign last_idx = (count_r == '0) ? '0 : cnt_ext - CMP_W'(1);

  // action decode: kind of access and target index
  always_comb begin
    do_put = 1'b0;
    do_get = 1'b0;
    do_rem = 1'b0;
    do_clr = 1'b0;
    tgt    = '0;
    unique case (ile_pkg::action_t'(req.action))
      ile_pkg::ACT_READ_AT: begin
        do_get = 1'b1;
        tgt    = CMP_W'(req.position);
      end
      ile_pkg::ACT_INSERT_AT: begin
        do_put = 1'b1;
        tgt    = CMP_W'(req.position);
      end
      ile_pkg::ACT_DELETE_AT: begin
        do_get = 1'b1;
        do_rem = 1'b1;
        tgt    = CMP_W'(req.position);
      end
      ile_pkg::ACT_PUSH_FRONT: begin
        do_put = 1'b1;
      end
      ile_pkg::ACT_POP_FRONT: begin
        do_get = 1'b1;
        do_rem = 1'b1;
      end
      ile_pkg::ACT_PUSH_BACK: begin
        do_put = 1'b1;
        tgt    = cnt_ext;
      end
      ile_pkg::ACT_POP_BACK: begin
        do_get = 1'b1;
        do_rem = 1'b1;
        tgt    = last_idx;
      end
      ile_pkg::ACT_PEEK_FRONT: begin
        do_get = 1'b1;
      end
      ile_pkg::ACT_PEEK_BACK: begin
        do_get = 1'b1;
        tgt    = last_idx;
      end
      ile_pkg::ACT_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
        do_put = 1'b0;
      end
    endcase
  end

  // status checks, range before full for inserts
  always_comb begin
    status = ile_pkg::ST_OK;
    if (do_put) begin
      priority if (tgt > cnt_ext) begin
        status = ile_pkg::ST_RANGE;
      end else if (cnt_ext == CMP_W'(CAPACITY)) begin
        status = ile_pkg::ST_FULL;
      end else begin
        status = ile_pkg::ST_OK;
      end
    end else if (do_get) begin
      priority if (count_r == '0) begin
        status = ile_pkg::ST_EMPTY;
      end else if (tgt >= cnt_ext) begin
        status = ile_pkg::ST_RANGE;
      end else begin
        status = ile_pkg::ST_OK;
      end
    end
  end

  assign put_ok = do_put && (status == ile_pkg::ST_OK);
  assign get_ok = do_get && (status == ile_pkg::ST_OK);
  assign rem_ok = do_rem && (status == ile_pkg::ST_OK);

  // result value and next count
  always_comb begin
    rsp_head.status    = status;
    rsp_head.value_out = get_ok ? entries_r[tgt[IDX_W-1:0]] : '0;
    priority if (do_clr) begin
      count_nxt = '0;
    end else if (put_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign empty_nxt = (count_nxt == '0);

  // per-entry shift mux: up by one on insert, down by one on remove
  for (genvar k = 0; k < CAPACITY; k++) begin : g_entry
    localparam logic [CMP_W-1:0] KI  = CMP_W'(k);
    localparam logic [CMP_W-1:0] KI1 = CMP_W'(k + 1);

    always_comb begin
      ent_nxt[k] = entries_r[k];
      if (put_ok) begin
        if (KI == tgt) begin
          ent_nxt[k] = req.value_in;
        end else if (KI > tgt && KI <= cnt_ext) begin
          if (k > 0) begin
            ent_nxt[k] = entries_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (rem_ok) begin
        if (KI >= tgt && KI1 < cnt_ext) begin
          ent_nxt[k] = entries_r[(k < CAPACITY - 1) ? k + 1 : k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (step) begin
        entries_r[k] <= ent_nxt[k];
      end
    end
  end

  // item count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(count_r) <= CNT_W'(CAPACITY))
    else $error("item count above capacity");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    step && put_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful insert did not grow the list");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    step && rem_ok |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("successful remove did not shrink the list");

  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && status != ile_pkg::ST_OK |=> $stable(count_r))
    else $error("failed request changed the count");

endmodule

// ===== rtl/ile_out_stage.sv =====
// ----------------------------------------------------------------------------
// ile_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ile_out_stage #(
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  output logic               free,
  input  ile_pkg::rsp_head_t head_in,
  input  logic [CNT_W-1:0]   count_in,
  input  logic               empty_in,
  output logic               out_valid,
  input  logic               out_ready,
  output ile_pkg::rsp_head_t head_out,
  output logic [CNT_W-1:0]   count_out,
  output logic               empty_out
);

  logic               valid_r;
  ile_pkg::rsp_head_t head_r;
  logic [CNT_W-1:0]   count_r;
  logic               empty_r;

  // room for a new result when empty or being drained
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign head_out  = head_r;
  assign count_out = count_r;
  assign empty_out = empty_r;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      head_r  <= head_in;
      count_r <= count_in;
      empty_r <= empty_in;
    end
  end

endmodule

// ===== tb/ile_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ile_list_checker
// Watches the request and result channels of the indexed list engine, keeps
// its own copy of the ordered list and compares every result beat, field by
// field, with the result predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module ile_list_checker #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ile_pkg::ACT_W-1:0]         in_action,
  input  logic [ile_pkg::POS_W-1:0]         in_position,
  input  logic signed [ile_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  ile_pkg::status_t                  out_status,
  input  logic signed [ile_pkg::DATA_W-1:0] out_value,
  input  logic [ile_pkg::POS_W-1:0]         out_count,
  input  logic                              out_empty,
  output int                                fail_count,
  output int                                pending,
  output int                                stored_count
);

  // one predicted result beat
  typedef struct packed {
    ile_pkg::status_t                  status;
    logic signed [ile_pkg::DATA_W-1:0] value;
    logic [ile_pkg::POS_W-1:0]         count;
    logic                              empty;
  } list_result_t;

  // shadow copy of the list
  logic signed [ile_pkg::DATA_W-1:0] list_mem [CAPACITY];
  int                                list_len;

  // results still owed by the block, oldest first
  list_result_t result_q[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    stored_count = 0;
    list_len     = 0;
  end

  // place an item at p, later entries move up one place
  function automatic ile_pkg::status_t list_insert(int p,
                                                   logic signed [ile_pkg::DATA_W-1:0] item);
    int k;
    if (p > list_len) return ile_pkg::ST_RANGE;
    if (list_len >= CAPACITY) return ile_pkg::ST_FULL;
    for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
    list_mem[p] = item;
    list_len++;
    return ile_pkg::ST_OK;
  endfunction

  // read the item at p, with take set it is removed and later entries move down
  function automatic ile_pkg::status_t list_fetch(int p, bit take,
                                                  output logic signed [ile_pkg::DATA_W-1:0] item);
    int k;
    item = '0;
    if (list_len == 0) return ile_pkg::ST_EMPTY;
    if (p >= list_len) return ile_pkg::ST_RANGE;
    item = list_mem[p];
    if (take) begin
      for (k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
      list_len--;
    end
    return ile_pkg::ST_OK;
  endfunction

  // run one request on the shadow list and form its result
  function automatic list_result_t predict_result(logic [ile_pkg::ACT_W-1:0] act,
                                                  logic [ile_pkg::POS_W-1:0] pos,
                                                  logic signed [ile_pkg::DATA_W-1:0] item);
    list_result_t                      res;
    logic signed [ile_pkg::DATA_W-1:0] got;
    int                                tail_idx;
    tail_idx   = (list_len > 0) ? list_len - 1 : 0;
    got        = '0;
    res.status = ile_pkg::ST_OK;
    case (act)
      ile_pkg::ACT_READ_AT:    res.status = list_fetch(int'(pos), 1'b0, got);
      ile_pkg::ACT_INSERT_AT:  res.status = list_insert(int'(pos), item);
      ile_pkg::ACT_DELETE_AT:  res.status = list_fetch(int'(pos), 1'b1, got);
      ile_pkg::ACT_PUSH_FRONT: res.status = list_insert(0, item);
      ile_pkg::ACT_POP_FRONT:  res.status = list_fetch(0, 1'b1, got);
      ile_pkg::ACT_PUSH_BACK:  res.status = list_insert(list_len, item);
      ile_pkg::ACT_POP_BACK:   res.status = list_fetch(tail_idx, 1'b1, got);
      ile_pkg::ACT_PEEK_FRONT: res.status = list_fetch(0, 1'b0, got);
      ile_pkg::ACT_PEEK_BACK:  res.status = list_fetch(tail_idx, 1'b0, got);
      ile_pkg::ACT_CLEAR:      list_len = 0;
      default: ;
    endcase
    res.value = (res.status == ile_pkg::ST_OK) ? got : '0;
    res.count = list_len[ile_pkg::POS_W-1:0];
    res.empty = (list_len == 0);
    return res;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      result_q.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat arrived with no request outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $error("value_out: expected %0d, actual %0d", want.value, out_value);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("item_count: expected %0d, actual %0d", want.count, out_count);
            fail_count++;
          end
          if (out_empty !== want.empty) begin
            $error("is_empty: expected %0d, actual %0d", want.empty, out_empty);
            fail_count++;
          end
        end
      end
      // request beat goes through the shadow list
      if (in_valid && in_ready)
        result_q.push_back(predict_result(in_action, in_position, in_value));
    end
    pending      = result_q.size();
    stored_count = list_len;
  end

endmodule

// ===== tb/tb_indexed_list_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine_top
// Drives list requests into the indexed list engine under changing idle and
// stall patterns, first a directed walk through the empty, range and end
// cases, then random fill, mixed and drain bursts; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_top;

  localparam int CAPACITY         = ile_pkg::CAPACITY_DEF;
  localparam int CNT_W            = $clog2(CAPACITY + 1);
  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RSP_HOLD_CYCLES  = 80;
  localparam int BURST_LEN        = 38;
  localparam int BURSTS_PER_PHASE = 10;
  localparam int NUM_PHASES       = 4;
  localparam int TAIL_CYCLES      = 4;

  localparam logic [ile_pkg::ACT_W-1:0] ACT_UNUSED_LO = 4'd10;
  localparam logic [ile_pkg::ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

  localparam logic [ile_pkg::POS_W-1:0] POS_END = CAPACITY[ile_pkg::POS_W-1:0];

  localparam logic signed [ile_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [ile_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  // leaning of a random burst
  typedef enum int {BIAS_FILL, BIAS_MIX, BIAS_DRAIN} bias_t;

  logic clk;
  logic rst_n;

  ile_req_if                  in_ch ();
  ile_rsp_if #(.CNT_W(CNT_W)) out_ch ();

  int fail_count;
  int pending;
  int stored_count;
  int quiet_cycles = 0;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  bit rsp_hold_req  = 1'b0;

  indexed_list_engine_top #(.CAPACITY(CAPACITY)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ile_list_checker #(.CAPACITY(CAPACITY)) list_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_action    (in_ch.action),
    .in_position  (in_ch.position),
    .in_value     (in_ch.value_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_value    (out_ch.value_out),
    .out_count    (out_ch.item_count),
    .out_empty    (out_ch.is_empty),
    .fail_count   (fail_count),
    .pending      (pending),
    .stored_count (stored_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // result side: random stalls, or one long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one request beat, called and returning at a falling edge
  task automatic send_request(input logic [ile_pkg::ACT_W-1:0] act,
                              input logic [ile_pkg::POS_W-1:0] pos,
                              input logic signed [ile_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    in_ch.value_in <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // random requests, leaning toward growing or shrinking the list
  task automatic run_burst(input bias_t bias, input int len);
    logic [ile_pkg::ACT_W-1:0]         act;
    logic [ile_pkg::POS_W-1:0]         pos;
    logic signed [ile_pkg::DATA_W-1:0] val;
    int                                put_pct;
    int                                r;
    int                                pick;
    put_pct = (bias == BIAS_FILL) ? 75 : (bias == BIAS_MIX) ? 45 : 20;
    repeat (len) begin
      // action
      r = $urandom_range(99);
      if (r == 0)
        act = ile_pkg::ACT_CLEAR;
      else if (r == 1) begin
        pick = $urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO);
        act  = pick[ile_pkg::ACT_W-1:0];
      end else if (r < put_pct + 2) begin
        case ($urandom_range(2))
          0:       act = ile_pkg::ACT_INSERT_AT;
          1:       act = ile_pkg::ACT_PUSH_FRONT;
          default: act = ile_pkg::ACT_PUSH_BACK;
        endcase
      end else begin
        case ($urandom_range(5))
          0:       act = ile_pkg::ACT_READ_AT;
          1:       act = ile_pkg::ACT_DELETE_AT;
          2:       act = ile_pkg::ACT_POP_FRONT;
          3:       act = ile_pkg::ACT_POP_BACK;
          4:       act = ile_pkg::ACT_PEEK_FRONT;
          default: act = ile_pkg::ACT_PEEK_BACK;
        endcase
      end
      // position, mostly near the current length
      r = $urandom_range(99);
      if (r < 80)
        pick = $urandom_range(stored_count, 0);
      else if (r < 95)
        pick = $urandom_range(CAPACITY, 0);
      else
        pick = $urandom_range(31, 0);
      pos = pick[ile_pkg::POS_W-1:0];
      // value, with the extremes now and then
      case ($urandom_range(9))
        0:       val = VAL_MAX;
        1:       val = VAL_MIN;
        2:       val = $urandom_range(1) ? '0 : '1;
        default: val = $urandom;
      endcase
      send_request(act, pos, val);
    end
  endtask

  // stimulus and verdict
  initial begin
    int phase;
    int b;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = '0;
    in_ch.position = '0;
    in_ch.value_in = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: every read and remove reports empty
    send_request(ile_pkg::ACT_READ_AT, 0, 0);
    send_request(ile_pkg::ACT_DELETE_AT, 0, 0);
    send_request(ile_pkg::ACT_POP_FRONT, 0, 0);
    send_request(ile_pkg::ACT_POP_BACK, 0, 0);
    send_request(ile_pkg::ACT_PEEK_FRONT, 0, 0);
    send_request(ile_pkg::ACT_PEEK_BACK, 0, 0);
    // insert past the end of an empty list
    send_request(ile_pkg::ACT_INSERT_AT, 1, 5);
    // build a short list from both ends, then insert far past the end
    send_request(ile_pkg::ACT_INSERT_AT, 0, VAL_MIN);
    send_request(ile_pkg::ACT_PUSH_BACK, 0, VAL_MAX);
    send_request(ile_pkg::ACT_PUSH_FRONT, 0, -1);
    send_request(ile_pkg::ACT_INSERT_AT, 3, 0);
    send_request(ile_pkg::ACT_INSERT_AT, POS_END, 7);
    // index at the count, then reads and removes within the list
    send_request(ile_pkg::ACT_READ_AT, 4, 0);
    send_request(ile_pkg::ACT_READ_AT, 2, 0);
    send_request(ile_pkg::ACT_DELETE_AT, 1, 0);
    send_request(ile_pkg::ACT_PEEK_FRONT, 0, 0);
    send_request(ile_pkg::ACT_PEEK_BACK, 0, 0);
    send_request(ile_pkg::ACT_POP_FRONT, 0, 0);
    send_request(ile_pkg::ACT_POP_BACK, 0, 0);
    // unused code, then clear
    send_request(ACT_UNUSED_HI, 0, 3);
    send_request(ile_pkg::ACT_CLEAR, 0, 0);
    send_request(ile_pkg::ACT_PEEK_BACK, 0, 0);
    wait_drain();

    // random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct = (phase == 1) ? 71 : (phase == 3) ? 20 : 0;
      rsp_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 20 : 0;
      for (b = 0; b < BURSTS_PER_PHASE; b++) begin
        // long result hold while requests keep coming, so the block backs up
        if (phase == 0 && b == 1)
          rsp_hold_req = 1'b1;
        run_burst(bias_t'(b % 3), BURST_LEN);
        if (phase == 0 && b == 1)
          wait_drain();
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
